>>> rtl/rrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and codes of the round-robin task table
// Request and result payloads, command and phase codes, and the control
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int CMD_W  = 3;
    localparam int PID_W  = 16;
    localparam int EXIT_W = 32;
    localparam int PH_W   = 2;
    localparam int REAP_W = 4;

    localparam logic [CMD_W-1:0] CMD_SPAWN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RETURN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PREEMPT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REAP     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

    localparam logic [PH_W-1:0] PH_FREE  = 2'd0;
    localparam logic [PH_W-1:0] PH_READY = 2'd1;
    localparam logic [PH_W-1:0] PH_RUN   = 2'd2;
    localparam logic [PH_W-1:0] PH_EXIT  = 2'h3;

    localparam logic [REAP_W-1:0] REAP_MAX = 4'hF;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              exited;
        logic [EXIT_W-1:0] exit_value;
        logic              from_user;
        logic [PID_W-1:0]  query_pid;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [PID_W-1:0]  chosen_pid;
        logic [PH_W-1:0]   slot_status;
        logic [EXIT_W-1:0] exit_status;
        logic [REAP_W-1:0] reaped_count;
        logic              ready_any;
        logic [PID_W-1:0]  running_pid;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // latch an accepted request
        logic step;    // issue the next slot of a scan
        logic check;   // slot issued last cycle is at the check stage
        logic exec;    // run a command that needs no scan
        logic finish;  // load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             run_busy;
        logic             hit;
    } dp_stat_t;

endpackage

>>> rtl/rrt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_req_if: request channel of the task table
// Valid/ready handshake carrying one command with its operands.
// ----------------------------------------------------------------------------
interface rrt_req_if;
    logic          valid;
    logic          ready;
    rrt_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rrt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_rsp_if: result channel of the task table
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface rrt_rsp_if;
    logic          valid;
    logic          ready;
    rrt_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/round_robin_task_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_table: round-robin task table with spawn, dispatch,
// return, preempt, reap and query
//
//   channel   role     payload
//   request   sink     command, exited, exit_value, from_user, query_pid
//   result    source   ok, chosen_pid, slot_status, exit_status,
//                      reaped_count, ready_any, running_pid
//
// Return, preempt, unused commands and a dispatch while a task runs go
// through decode and execute to the result register. Spawn, query and a
// dispatch with none running scan one slot per cycle behind a registered
// memory read and stop at the first match; reap always walks every slot.
// One request is in work at a time. Reset clears the used and phase
// marks at once, no clearing pass. A stalled result holds in the output
// register while the next request is taken; that one finishes once free.
// ----------------------------------------------------------------------------
module round_robin_task_table #(
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rrt_req_if.sink   request,
    rrt_rsp_if.source result
);

    rrt_pkg::ctrl_cmd_t cmd;
    rrt_pkg::dp_stat_t  stat;
    logic               in_ready;
    logic               out_valid;

    rrt_controller #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rrt_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (request.data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_data (result.data)
    );

    assign request.ready = in_ready;
    assign result.valid  = out_valid;

endmodule

>>> rtl/rrt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_controller: sequencer of the task table
// Accepts a request, runs either a direct command or a slot scan with a
// registered read stage, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rrt_controller #(
    parameter int SLOTS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rrt_pkg::ctrl_cmd_t   cmd,
    input  rrt_pkg::dp_stat_t    stat
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EXEC,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               chk_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic               stop;
    logic               scan_op;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign scan_op = (stat.op == rrt_pkg::CMD_SPAWN) || (stat.op == rrt_pkg::CMD_QUERY) ||
                     (stat.op == rrt_pkg::CMD_REAP) ||
                     ((stat.op == rrt_pkg::CMD_DISPATCH) && !stat.run_busy);

    // end the scan on a match or once the last slot has been checked
    assign stop = chk_reg && (stat.hit || last_reg);

    always_comb
    begin
        cmd        = '0;
        cmd.load   = in_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_SCAN:
            begin
                cmd.check = chk_reg;
                cmd.step  = !stop && (cnt_reg < CNT_W'(SLOTS));
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_FIN:
            begin
                cmd.finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd.check = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            chk_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    cnt_reg   <= '0;
                    chk_reg   <= 1'b0;
                    last_reg  <= 1'b0;
                    state_reg <= scan_op ? S_SCAN : S_EXEC;
                end
                S_SCAN:
                begin
                    chk_reg  <= cmd.step;
                    last_reg <= cmd.step && (cnt_reg == CNT_W'(SLOTS - 1));
                    if (cmd.step)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (stop)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (cmd.finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/rrt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_datapath: slot table, scheduler registers and result register
// Used and phase marks sit in flip-flops; ids and exit codes sit in
// memories with a registered read, gated by the used mark.
// ----------------------------------------------------------------------------
module rrt_datapath #(
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrt_pkg::req_t        req_data,
    input  rrt_pkg::ctrl_cmd_t   cmd,
    output rrt_pkg::dp_stat_t    stat,
    output rrt_pkg::rsp_t        rsp_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (ID_BITS > rrt_pkg::PID_W) ? ID_BITS : rrt_pkg::PID_W;
    localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(SLOTS - 1);

    rrt_pkg::req_t                  req_q_reg;
    rrt_pkg::rsp_t                  rsp_reg;

    logic                           used_reg  [SLOTS];
    logic [rrt_pkg::PH_W-1:0]       phase_reg [SLOTS];
    logic [ID_BITS-1:0]             pid_mem   [SLOTS];
    logic [rrt_pkg::EXIT_W-1:0]     exit_mem  [SLOTS];
    logic [ID_BITS-1:0]             pid_rd_reg;
    logic [rrt_pkg::EXIT_W-1:0]     exit_rd_reg;

    logic [IDX_W-1:0]               idx_reg;
    logic [IDX_W-1:0]               idx_d_reg;
    logic [ID_BITS-1:0]             next_id_reg;
    logic [ID_BITS-1:0]             running_id_reg;
    logic [IDX_W-1:0]               running_slot_reg;
    logic [IDX_W-1:0]               scan_start_reg;
    logic [CNT_W-1:0]               ready_cnt_reg;
    logic [CNT_W-1:0]               ready_cnt_next;

    logic                           res_ok_reg;
    logic [rrt_pkg::PID_W-1:0]      res_chosen_reg;
    logic [rrt_pkg::PH_W-1:0]       res_status_reg;
    logic [rrt_pkg::EXIT_W-1:0]     res_exit_reg;
    logic [rrt_pkg::REAP_W-1:0]     res_reaped_reg;

    logic [rrt_pkg::CMD_W-1:0]      op;
    logic                           cur_used;
    logic [rrt_pkg::PH_W-1:0]       cur_phase;
    logic                           run_busy;
    logic                           spawn_hit;
    logic                           disp_hit;
    logic                           query_hit;
    logic                           reap_hit;
    logic                           ret_ok;
    logic                           pre_ok;
    logic [IDX_W-1:0]               idx_inc;
    logic [IDX_W-1:0]               start_after;
    logic [ID_BITS-1:0]             next_id_inc;
    logic                           pid_we;
    logic                           exit_we;
    logic [IDX_W-1:0]               exit_waddr;
    logic [rrt_pkg::EXIT_W-1:0]     exit_wdata;

    assign op        = req_q_reg.command;
    assign cur_used  = used_reg[idx_d_reg];
    assign cur_phase = phase_reg[idx_d_reg];
    assign run_busy  = (running_id_reg != '0);

    assign spawn_hit = (op == rrt_pkg::CMD_SPAWN) && !cur_used;
    assign disp_hit  = (op == rrt_pkg::CMD_DISPATCH) && cur_used &&
                       (cur_phase == rrt_pkg::PH_READY);
    assign query_hit = (op == rrt_pkg::CMD_QUERY) && cur_used &&
                       (CMP_W'(pid_rd_reg) == CMP_W'(req_q_reg.query_pid));
    assign reap_hit  = (op == rrt_pkg::CMD_REAP) && cur_used &&
                       (cur_phase == rrt_pkg::PH_EXIT);
    assign ret_ok    = (op == rrt_pkg::CMD_RETURN) && run_busy;
    assign pre_ok    = (op == rrt_pkg::CMD_PREEMPT) && run_busy && req_q_reg.from_user &&
                       (ready_cnt_reg != '0);

    assign stat.op       = op;
    assign stat.run_busy = run_busy;
    assign stat.hit      = spawn_hit || disp_hit || query_hit;

    assign idx_inc     = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
    assign start_after = (idx_d_reg == IDX_LAST) ? '0 : idx_d_reg + IDX_W'(1);
    assign next_id_inc = (next_id_reg == ID_MAX) ? ID_BITS'(1) : next_id_reg + ID_BITS'(1);

    assign pid_we     = cmd.check && spawn_hit;
    assign exit_we    = (cmd.check && spawn_hit) || (cmd.exec && ret_ok && req_q_reg.exited);
    assign exit_waddr = (cmd.check && spawn_hit) ? idx_d_reg : running_slot_reg;
    assign exit_wdata = (cmd.check && spawn_hit) ? '0 : req_q_reg.exit_value;

    // ready count stands in for an OR over all phase marks
    always_comb
    begin
        ready_cnt_next = ready_cnt_reg;
        if (cmd.check && spawn_hit)
        begin
            ready_cnt_next = ready_cnt_reg + CNT_W'(1);
        end
        else if (cmd.check && disp_hit)
        begin
            ready_cnt_next = ready_cnt_reg - CNT_W'(1);
        end
        else if (cmd.exec && ((ret_ok && !req_q_reg.exited) || pre_ok))
        begin
            ready_cnt_next = ready_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pid_we)
        begin
            pid_mem[idx_d_reg] <= next_id_reg;
        end
        if (cmd.step)
        begin
            pid_rd_reg <= pid_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_we)
        begin
            exit_mem[exit_waddr] <= exit_wdata;
        end
        if (cmd.step)
        begin
            exit_rd_reg <= exit_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i]  <= 1'b0;
                phase_reg[i] <= rrt_pkg::PH_FREE;
            end
            next_id_reg      <= ID_BITS'(1);
            running_id_reg   <= '0;
            running_slot_reg <= '0;
            scan_start_reg   <= '0;
            ready_cnt_reg    <= '0;
        end
        else
        begin
            ready_cnt_reg <= ready_cnt_next;
            if (cmd.check && spawn_hit)
            begin
                used_reg[idx_d_reg]  <= 1'b1;
                phase_reg[idx_d_reg] <= rrt_pkg::PH_READY;
                next_id_reg          <= next_id_inc;
            end
            if (cmd.check && disp_hit)
            begin
                phase_reg[idx_d_reg] <= rrt_pkg::PH_RUN;
                running_id_reg       <= pid_rd_reg;
                running_slot_reg     <= idx_d_reg;
                scan_start_reg       <= start_after;
            end
            if (cmd.check && reap_hit)
            begin
                used_reg[idx_d_reg]  <= 1'b0;
                phase_reg[idx_d_reg] <= rrt_pkg::PH_FREE;
            end
            if (cmd.exec && ret_ok)
            begin
                phase_reg[running_slot_reg] <= req_q_reg.exited ? rrt_pkg::PH_EXIT :
                                                                   rrt_pkg::PH_READY;
                running_id_reg <= '0;
            end
            if (cmd.exec && pre_ok)
            begin
                phase_reg[running_slot_reg] <= rrt_pkg::PH_READY;
                running_id_reg              <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_q_reg      <= req_data;
            idx_reg        <= (req_data.command == rrt_pkg::CMD_DISPATCH) ? scan_start_reg : '0;
            res_ok_reg     <= (req_data.command == rrt_pkg::CMD_REAP);
            res_chosen_reg <= '0;
            res_status_reg <= rrt_pkg::PH_FREE;
            res_exit_reg   <= '0;
            res_reaped_reg <= '0;
        end
        if (cmd.step)
        begin
            idx_d_reg <= idx_reg;
            idx_reg   <= idx_inc;
        end
        if (cmd.check && spawn_hit)
        begin
            res_ok_reg     <= 1'b1;
            res_chosen_reg <= rrt_pkg::PID_W'(next_id_reg);
        end
        if (cmd.check && disp_hit)
        begin
            res_ok_reg     <= 1'b1;
            res_chosen_reg <= rrt_pkg::PID_W'(pid_rd_reg);
        end
        if (cmd.check && query_hit)
        begin
            res_ok_reg     <= 1'b1;
            res_status_reg <= cur_phase;
            res_exit_reg   <= exit_rd_reg;
        end
        if (cmd.check && reap_hit && (res_reaped_reg != rrt_pkg::REAP_MAX))
        begin
            res_reaped_reg <= res_reaped_reg + rrt_pkg::REAP_W'(1);
        end
        if (cmd.exec)
        begin
            res_ok_reg <= ret_ok || pre_ok;
        end
        if (cmd.finish)
        begin
            rsp_reg.ok           <= res_ok_reg;
            rsp_reg.chosen_pid   <= res_chosen_reg;
            rsp_reg.slot_status  <= res_status_reg;
            rsp_reg.exit_status  <= res_exit_reg;
            rsp_reg.reaped_count <= res_reaped_reg;
            rsp_reg.ready_any    <= (ready_cnt_reg != '0);
            rsp_reg.running_pid  <= rrt_pkg::PID_W'(running_id_reg);
        end
    end

    assign rsp_data = rsp_reg;

endmodule
